/* design/bqfrm_pkg.sv */
// bqfrm_pkg: operation and status codes of the bounded queue with max pop
// shared by the core and its checker; no dependencies
`default_nettype none

package bqfrm_pkg;

    localparam int FUNC_W   = 3;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ROTATE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MAXPOP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* design/bqfrm_ram.sv */
// bqfrm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bqfrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/bounded_queue_fifo_rotate_max_pop_core.sv */
// bounded_queue_fifo_rotate_max_pop_core: queue sequencer around one entry ram
// depends on bqfrm_pkg and bqfrm_ram
//
// Bounded queue of signed words held in order in a single ram, front at
// address 0. One operation is taken at a time on the s_ stream and one result
// word comes back on the m_ stream. Push, clear, unused codes and operations
// refused on an empty queue go straight to the done state; pop and
// rotate shift the entries behind the front forward, one entry moved per cycle
// through the single read port; max pop makes a scan pass over all entries,
// then a shift pass behind the removed one, longest when the front entry goes.
// A new operation is accepted as soon as the sequencer is idle, even while the
// previous result still waits in the output register.
// Capacity is written on the cfg channel; the user must write it only while
// the queue is idle, the core does not enforce this. It saturates at DEPTH.
`default_nettype none

module bounded_queue_fifo_rotate_max_pop_core
    import bqfrm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // func [2:0], value [DATA_WIDTH+2:3]
    input  wire logic [((FUNC_W+DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // front_value, count, full_res, empty_res, status (lowest bit up)
    output logic [((DATA_WIDTH+$clog2(DEPTH+1)+2+STATUS_W+7)/8)*8-1:0] m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [CAP_W-1:0]      cfg_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int OW   = ((DATA_WIDTH + CW + 2 + STATUS_W + 7) / 8) * 8;
    localparam int CAP_RESET = (DEPTH > 31) ? 31 : DEPTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [DATA_WIDTH-1:0] best_val_reg, best_val_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_front_reg, out_front_next;
    logic [CW-1:0]         out_count_reg, out_count_next;
    logic                  out_full_reg, out_full_next;
    logic                  out_empty_reg, out_empty_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [FUNC_W-1:0]     in_func;
    logic [DATA_WIDTH-1:0] in_value;
    logic [CMPW-1:0]       cap_wide;
    logic [CW-1:0]         cap_eff;
    logic [CW-1:0]         count_dec;
    logic                  pass_end;

    assign in_func   = s_tdata[FUNC_W-1:0];
    assign in_value  = s_tdata[FUNC_W +: DATA_WIDTH];
    assign cap_wide  = CMPW'(cap_reg);
    assign cap_eff   = (cap_wide > CMPW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_wide);
    assign count_dec = count_reg - CW'(1);
    assign pass_end  = (rd_ptr_reg == count_reg) && !pend_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OW'({out_status_reg, out_empty_reg, out_full_reg,
                            out_count_reg, out_front_reg});

    bqfrm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        hold_next       = hold_reg;
        func_next       = func_reg;
        status_next     = status_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_front_next  = out_front_reg;
        out_count_next  = out_count_reg;
        out_full_next   = out_full_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        // one read per cycle during either pass, data comes back next cycle
        if ((state_reg == ST_SCAN || state_reg == ST_SHIFT) && rd_ptr_reg < count_reg)
        begin
            ram_re         = 1'b1;
            ram_raddr      = rd_ptr_reg[AW-1:0];
            rd_ptr_next    = rd_ptr_reg + CW'(1);
            pend_next      = 1'b1;
            pend_addr_next = rd_ptr_reg[AW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = in_func;
                    status_next = STATUS_OK;
                    hold_next   = front_reg;
                    state_next  = ST_DONE;
                    case (in_func)
                        FUNC_PUSH:
                        begin
                            if (count_reg < cap_eff)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    front_next = in_value;
                                end
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        FUNC_POP, FUNC_ROTATE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_ptr_next = CW'(1);
                                state_next  = ST_SHIFT;
                            end
                        end
                        FUNC_MAXPOP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_ptr_next = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // >= keeps the last occurrence of the greatest value
                if (pend_reg)
                begin
                    if (pend_addr_reg == '0 ||
                        $signed(ram_rdata) >= $signed(best_val_reg))
                    begin
                        best_val_next = ram_rdata;
                        best_idx_next = pend_addr_reg;
                    end
                end
                if (pass_end)
                begin
                    rd_ptr_next = CW'(best_idx_reg) + CW'(1);
                    state_next  = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg - AW'(1);
                    ram_wdata = ram_rdata;
                    if (pend_addr_reg == AW'(1))
                    begin
                        front_next = ram_rdata;
                    end
                end
                if (pass_end)
                begin
                    // write port is free here, old head goes to the back
                    if (func_reg == FUNC_ROTATE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = count_dec[AW-1:0];
                        ram_wdata = hold_reg;
                    end
                    else
                    begin
                        count_next = count_dec;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_front_next  = (count_reg == '0) ? '0 : front_reg;
                    out_count_next  = count_reg;
                    out_full_next   = (count_reg >= cap_eff);
                    out_empty_next  = (count_reg == '0);
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(CAP_RESET);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        hold_reg       <= hold_next;
        func_reg       <= func_next;
        status_reg     <= status_next;
        rd_ptr_reg     <= rd_ptr_next;
        pend_addr_reg  <= pend_addr_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        out_front_reg  <= out_front_next;
        out_count_reg  <= out_count_next;
        out_full_reg   <= out_full_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

/* design/bqfrm_checker.sv */
// bqfrm_checker: port-level assertions for the bounded queue core, bound to the top
// depends on bqfrm_pkg
`default_nettype none

module bqfrm_checker
    import bqfrm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((DATA_WIDTH+$clog2(DEPTH+1)+2+STATUS_W+7)/8)*8-1:0] m_tdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int FULL  = DATA_WIDTH + CW;
    localparam int EMPTY = FULL + 1;
    localparam int STAT  = EMPTY + 1;

    logic [DATA_WIDTH-1:0] front;
    logic [CW-1:0]         count;
    logic                  full;
    logic                  empty;
    logic [STATUS_W-1:0]   status;

    assign front  = m_tdata[DATA_WIDTH-1:0];
    assign count  = m_tdata[DATA_WIDTH +: CW];
    assign full   = m_tdata[FULL];
    assign empty  = m_tdata[EMPTY];
    assign status = m_tdata[STAT +: STATUS_W];

    // one word at a time: the sequencer is busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && empty) |-> (front == '0 && count == '0))
        else $error("empty result with nonzero front or count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status == STATUS_FULL) |-> full)
        else $error("push rejected while not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status == STATUS_EMPTY) |-> (empty && count == '0))
        else $error("removal rejected while not empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind bounded_queue_fifo_rotate_max_pop_core bqfrm_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_bqfrm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/bqfrm_queue_checker.sv */
`timescale 1ns / 100ps
// bqfrm_queue_checker: watches the op, result and capacity channels of the queue core,
// keeps its own model of the queue and compares every result word field by field
// depends on bqfrm_pkg

module bqfrm_queue_checker
    import bqfrm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [((FUNC_W+DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [((DATA_WIDTH+$clog2(DEPTH+1)+2+STATUS_W+7)/8)*8-1:0] m_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [CAP_W-1:0]      cfg_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    output int                         fail_count,
    output int                         open_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct {
        logic [DATA_WIDTH-1:0] front_value;
        logic [CNT_W-1:0]      count;
        logic                  full_res;
        logic                  empty_res;
        logic [STATUS_W-1:0]   status;
    } queue_view_t;

    logic signed [DATA_WIDTH-1:0] held[$];
    logic [CAP_W-1:0]             capacity;
    queue_view_t                  views_due[$];

    // applies one operation to the model queue and returns what the core should report
    function automatic queue_view_t step_queue(input logic [FUNC_W-1:0] func,
                                               input logic signed [DATA_WIDTH-1:0] word);
        queue_view_t v;
        int          limit;
        int          top_idx;
        limit = (capacity > DEPTH) ? DEPTH : capacity;
        v.status = STATUS_OK;
        case (func)
            FUNC_PUSH:
                if (held.size() < limit)
                    held.push_back(word);
                else
                    v.status = STATUS_FULL;
            FUNC_POP:
                if (held.size() == 0)
                    v.status = STATUS_EMPTY;
                else
                    held.delete(0);
            FUNC_ROTATE:
                if (held.size() == 0)
                    v.status = STATUS_EMPTY;
                else
                begin
                    held.push_back(held[0]);
                    held.delete(0);
                end
            FUNC_MAXPOP:
                if (held.size() == 0)
                    v.status = STATUS_EMPTY;
                else
                begin
                    // ties go to the entry nearest the back
                    top_idx = 0;
                    for (int i = 1; i < held.size(); i++)
                        if (held[i] >= held[top_idx])
                            top_idx = i;
                    held.delete(top_idx);
                end
            FUNC_CLEAR:
                held.delete();
            default:
                ;
        endcase
        v.front_value = (held.size() != 0) ? held[0] : '0;
        v.count       = CNT_W'(held.size());
        v.full_res    = (held.size() >= limit);
        v.empty_res   = (held.size() == 0);
        return v;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        queue_view_t got;
        queue_view_t want;
        if (!rst_n)
        begin
            held.delete();
            views_due.delete();
            capacity = CAP_W'(DEPTH);
            fail_count = 0;
            open_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.front_value = m_tdata[DATA_WIDTH-1:0];
                got.count       = m_tdata[DATA_WIDTH +: CNT_W];
                got.full_res    = m_tdata[DATA_WIDTH+CNT_W];
                got.empty_res   = m_tdata[DATA_WIDTH+CNT_W+1];
                got.status      = m_tdata[DATA_WIDTH+CNT_W+2 +: STATUS_W];
                if (views_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result word with no operation pending, got front %0d count %0d",
                             $time, $signed(got.front_value), got.count);
                end
                else
                begin
                    want = views_due.pop_front();
                    check_field("front_value", $signed(want.front_value),
                                $signed(got.front_value));
                    check_field("count", want.count, got.count);
                    check_field("full_res", want.full_res, got.full_res);
                    check_field("empty_res", want.empty_res, got.empty_res);
                    check_field("status", want.status, got.status);
                end
            end
            if (s_tvalid && s_tready)
                views_due.push_back(step_queue(s_tdata[FUNC_W-1:0],
                                               s_tdata[FUNC_W +: DATA_WIDTH]));
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            open_count <= views_due.size();
        end
    end

endmodule

/* sim/bounded_queue_fifo_rotate_max_pop_core_test.sv */
`timescale 1ns / 100ps
// bounded_queue_fifo_rotate_max_pop_core_test: drives operations and capacity writes into
// the queue core, toggles back pressure and gives the verdict
// depends on bqfrm_pkg, the core and bqfrm_queue_checker

module bounded_queue_fifo_rotate_max_pop_core_test
    import bqfrm_pkg::*;
;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int S_W        = ((FUNC_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_W        = ((DATA_WIDTH + CNT_W + 2 + STATUS_W + 7) / 8) * 8;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STALL_CYCLES   = 300;
    localparam int BATCHES        = 24;
    localparam int BATCH_WORDS    = 80;

    // codes the core treats as no operation
    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic [S_W-1:0]       s_tdata;   // func, value
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_W-1:0]       m_tdata;   // front_value, count, full_res, empty_res, status
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CAP_W-1:0]     cfg_data;
    logic                 cfg_valid;
    logic                 cfg_ready;

    int                   fail_count;
    int                   open_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    // toggled to ask the receiver for one long hold
    logic                 stall_request;
    int                   quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bounded_queue_fifo_rotate_max_pop_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    bqfrm_queue_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_data   (cfg_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // result side back pressure, with a long hold when asked for
    initial
    begin
        logic stall_seen;
        m_tready   = 1'b0;
        stall_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request != stall_seen)
            begin
                stall_seen = stall_request;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue_word(input logic [FUNC_W-1:0] f, input logic [DATA_WIDTH-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W-FUNC_W-DATA_WIDTH){1'b0}}, v, f};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering and wait until every result word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        cfg_data  <= c;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_W-1:0]      cap_plan [8];
        logic [FUNC_W-1:0]     f;
        logic [DATA_WIDTH-1:0] v;
        int                    push_pct;
        int                    r;
        cap_plan = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd16};
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        stall_request = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 65;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // every code but push on an empty queue
        issue_word(FUNC_POP, '0);
        issue_word(FUNC_ROTATE, '0);
        issue_word(FUNC_MAXPOP, '0);
        issue_word(FUNC_CLEAR, '0);
        issue_word(FUNC_RSVD5, 32'hFFFF_FFFF);
        issue_word(FUNC_RSVD6, '0);
        issue_word(FUNC_RSVD7, 32'h1234_5678);
        // extremes, with a tie on the greatest value
        issue_word(FUNC_PUSH, 32'h7FFF_FFFF);
        issue_word(FUNC_PUSH, 32'h8000_0000);
        issue_word(FUNC_PUSH, 32'h0000_0000);
        issue_word(FUNC_PUSH, 32'hFFFF_FFFF);
        issue_word(FUNC_PUSH, 32'h7FFF_FFFF);
        issue_word(FUNC_PUSH, 32'h0000_0005);
        issue_word(FUNC_ROTATE, '0);
        issue_word(FUNC_MAXPOP, '0);
        issue_word(FUNC_POP, '0);
        issue_word(FUNC_MAXPOP, '0);
        issue_word(FUNC_CLEAR, '0);
        // rotate with a single entry
        issue_word(FUNC_PUSH, 32'h5555_AAAA);
        issue_word(FUNC_ROTATE, '0);
        issue_word(FUNC_POP, '0);

        for (int b = 0; b < BATCHES; b++)
        begin
            if (b == 8)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 19;
            end
            if (b == 16)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (b < 8)
                set_capacity(cap_plan[b]);
            else if ($urandom_range(2) == 0)
                set_capacity(CAP_W'(DEPTH));
            else
                set_capacity(CAP_W'($urandom_range(31)));
            case ($urandom_range(3))
                0:       push_pct = 35;
                1:       push_pct = 55;
                2:       push_pct = 75;
                default: push_pct = 90;
            endcase
            // fill up first so that the smaller capacity after it sits below the count
            if (b == 0)
                push_pct = 90;
            if (b == 4 || b == 18)
                stall_request = ~stall_request;
            for (int n = 0; n < BATCH_WORDS; n++)
            begin
                r = $urandom_range(99);
                if (r < push_pct)
                    f = FUNC_PUSH;
                else if (r < 98)
                begin
                    case ($urandom_range(2))
                        0:       f = FUNC_POP;
                        1:       f = FUNC_ROTATE;
                        default: f = FUNC_MAXPOP;
                    endcase
                end
                else if (r == 98)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_RSVD5 + FUNC_W'($urandom_range(2));
                // small values make ties in max pop likely
                case ($urandom_range(9))
                    0, 1:    v = $urandom_range(4) - 2;
                    2:
                    begin
                        case ($urandom_range(3))
                            0:       v = 32'h7FFF_FFFF;
                            1:       v = 32'h8000_0000;
                            2:       v = 32'h0000_0000;
                            default: v = 32'hFFFF_FFFF;
                        endcase
                    end
                    default: v = $urandom;
                endcase
                issue_word(f, v);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/bqfrm_pkg.sv
design/bqfrm_ram.sv
design/bounded_queue_fifo_rotate_max_pop_core.sv
design/bqfrm_checker.sv
sim/bqfrm_queue_checker.sv
sim/bounded_queue_fifo_rotate_max_pop_core_test.sv
